// ===== src/multi_client_heartbeat_watchdog_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MULTI_CLIENT_HEARTBEAT_WATCHDOG_MACROS_SVH
`define MULTI_CLIENT_HEARTBEAT_WATCHDOG_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MCHW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heartbeat watchdog check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MCHW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heartbeat watchdog check failed");

`endif

// ===== src/mchw_pkg.sv =====
`default_nettype none

package mchw_pkg;

  localparam int unsigned CLIENTS_DEF = 8;
  localparam int unsigned ClientW     = 4;
  localparam int unsigned TickW       = 16;
  localparam int unsigned CntW        = 8;
  localparam int unsigned CauseW      = 2;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [TickW-1:0] PERIOD_RST = 16'd100;
  localparam logic [CntW-1:0]  LIMIT_RST  = 8'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT  = 1'b1;

  // input item kinds
  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_TICK      = 1'b1;

  // fault causes
  localparam logic [CauseW-1:0] CAUSE_NONE        = 2'd0;
  localparam logic [CauseW-1:0] CAUSE_ZERO_PERIOD = 2'd1;
  localparam logic [CauseW-1:0] CAUSE_MISSED      = 2'd2;

  typedef struct packed {
    logic               start;
    logic               hb_we;
    logic [ClientW-1:0] hb_idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic healthy;
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== src/mchw_scan.sv =====
`default_nettype none

module mchw_scan #(
  parameter int unsigned CLIENTS = mchw_pkg::CLIENTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mchw_pkg::scan_ctrl_t      ctrl_i,
  input  wire logic [mchw_pkg::CntW-1:0] limit_i,
  output mchw_pkg::scan_stat_t           stat_o
);

  localparam int unsigned IdxW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CLIENTS - 1);

  logic [CLIENTS-1:0]         seen_q;
  logic [mchw_pkg::CntW-1:0]  missed_q [CLIENTS];
  logic [mchw_pkg::CntW-1:0]  missed_d;
  logic [mchw_pkg::CntW-1:0]  missed_cur;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic                       busy_q, busy_d;
  logic                       healthy_q, healthy_d;
  logic                       last;
  logic                       fail;

  assign missed_cur = missed_q[idx_q];
  assign last       = (idx_q == IdxLast);

  // one client per cycle: clear on seen, else count up to the limit
  always_comb begin
    if (seen_q[idx_q]) begin
      missed_d = '0;
    end else if (missed_cur < limit_i) begin
      missed_d = missed_cur + 1'b1;
    end else begin
      missed_d = missed_cur;
    end
    fail = (missed_d >= limit_i);
  end

  always_comb begin
    busy_d    = busy_q;
    idx_d     = idx_q;
    healthy_d = healthy_q;
    if (ctrl_i.start) begin
      busy_d    = 1'b1;
      idx_d     = '0;
      healthy_d = 1'b1;
    end else if (busy_q) begin
      healthy_d = healthy_q & ~fail;
      idx_d     = idx_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      healthy_q <= 1'b1;
      seen_q    <= '0;
      for (int i = 0; i < int'(CLIENTS); i++) begin
        missed_q[i] <= '0;
      end
    end else begin
      busy_q    <= busy_d;
      idx_q     <= idx_d;
      healthy_q <= healthy_d;
      if (!ctrl_i.start && busy_q) begin
        missed_q[idx_q] <= missed_d;
        seen_q[idx_q]   <= 1'b0;
      end else if (ctrl_i.hb_we) begin
        seen_q[ctrl_i.hb_idx[IdxW-1:0]] <= 1'b1;
      end
    end
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.done    = busy_q & last;
  assign stat_o.healthy = healthy_q & ~fail;

endmodule

`default_nettype wire

// ===== src/multi_client_heartbeat_watchdog.sv =====
`default_nettype none

// Heartbeat watchdog for up to CLIENTS clients. Each input item is a
// heartbeat (kind 0, with a client index; indexes at or above CLIENTS are
// dropped) or a tick (kind 1). Once the check period (register 0, a count of
// ticks) has elapsed, a health check runs: clients that sent a heartbeat
// since the last check have their missed count cleared, all others count up
// to the limit (register 1); if any client sits at or above it a fault latches
// (cause 2), otherwise the item's result carries refresh = 1. A zero period
// latches a fault (cause 1) on the next item. The fault holds until reset.
// Every item gives exactly one result. With the output register free, a
// heartbeat or a tick that does not end a period goes from the idle state
// through the result state into the result register; a tick that ends a
// period first passes through the scan state, where one shared update/compare
// unit walks the client counters one per cycle. Input is not ready while an
// item is in work, and a finished item also waits for the output register to
// empty; a result waiting in the output register does not stall the next
// transfer in. Configuration writes take effect at once and are meant for
// idle periods only.
module multi_client_heartbeat_watchdog #(
  parameter int unsigned CLIENTS = mchw_pkg::CLIENTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [mchw_pkg::ClientW-1:0]  client_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               refresh_o,
  output logic                               fault_o,
  output logic [mchw_pkg::CauseW-1:0]        fault_cause_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mchw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mchw_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  localparam int unsigned TickW = mchw_pkg::TickW;

  logic [1:0]                    state_q, state_d;
  logic [TickW-1:0]              period_q;
  logic [mchw_pkg::CntW-1:0]     limit_q;
  logic [TickW-1:0]              tick_q, tick_d;
  logic                          fault_q, fault_d;
  logic [mchw_pkg::CauseW-1:0]   cause_q, cause_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic                          refresh_q, refresh_d;
  logic                          ofault_q;
  logic [mchw_pkg::CauseW-1:0]   ocause_q;
  logic                          in_xfer;
  logic                          load;
  logic [TickW:0]                tick_next;
  logic                          in_range;
  mchw_pkg::scan_ctrl_t          scan_ctrl;
  mchw_pkg::scan_stat_t          scan_stat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign load       = (state_q == S_RESULT) & (~out_valid_q | out_ready_i);
  assign tick_next  = {1'b0, tick_q} + 1'b1;
  assign in_range   = ({1'b0, client_i} < (mchw_pkg::ClientW + 1)'(CLIENTS));

  always_comb begin
    state_d          = state_q;
    tick_d           = tick_q;
    fault_d          = fault_q;
    cause_d          = cause_q;
    pend_d           = pend_q;
    scan_ctrl.start  = 1'b0;
    scan_ctrl.hb_we  = 1'b0;
    scan_ctrl.hb_idx = client_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          pend_d  = 1'b0;
          state_d = S_RESULT;
          if (fault_q) begin
            // latched: drop the item
          end else if (period_q == '0) begin
            fault_d = 1'b1;
            cause_d = mchw_pkg::CAUSE_ZERO_PERIOD;
          end else if (kind_i == mchw_pkg::KIND_HEARTBEAT) begin
            scan_ctrl.hb_we = in_range;
          end else if (tick_next >= {1'b0, period_q}) begin
            tick_d          = '0;
            scan_ctrl.start = 1'b1;
            state_d         = S_SCAN;
          end else begin
            tick_d = tick_next[TickW-1:0];
          end
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_d = S_RESULT;
          if (scan_stat.healthy) begin
            pend_d = 1'b1;
          end else begin
            fault_d = 1'b1;
            cause_d = mchw_pkg::CAUSE_MISSED;
          end
        end
      end
      S_RESULT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    refresh_d   = refresh_q;
    if (load) begin
      out_valid_d = 1'b1;
      refresh_d   = pend_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= mchw_pkg::PERIOD_RST;
      limit_q     <= mchw_pkg::LIMIT_RST;
      tick_q      <= '0;
      fault_q     <= 1'b0;
      cause_q     <= mchw_pkg::CAUSE_NONE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      fault_q     <= fault_d;
      cause_q     <= cause_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mchw_pkg::REG_PERIOD: period_q <= cfg_wdata_i;
          mchw_pkg::REG_LIMIT:  limit_q  <= cfg_wdata_i[mchw_pkg::CntW-1:0];
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    refresh_q <= refresh_d;
    if (load) begin
      ofault_q <= fault_q;
      ocause_q <= cause_q;
    end
  end

  mchw_scan #(
    .CLIENTS(CLIENTS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .limit_i(limit_q),
    .stat_o (scan_stat)
  );

  assign out_valid_o   = out_valid_q;
  assign refresh_o     = refresh_q & ~scan_stat.busy | refresh_q;
  assign fault_o       = ofault_q;
  assign fault_cause_o = ocause_q;

endmodule

`default_nettype wire

// ===== src/mchw_checker.sv =====
`default_nettype none

`include "multi_client_heartbeat_watchdog_macros.svh"

module mchw_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          refresh_o,
  input wire logic                          fault_o,
  input wire logic [mchw_pkg::CauseW-1:0]   fault_cause_o
);

  logic                        in_xfer;
  logic                        out_xfer;
  logic [1:0]                  pending_q;
  logic                        seen_fault_q;
  logic [mchw_pkg::CauseW-1:0] seen_cause_q;

  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // track items in flight and the first fault reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      seen_fault_q <= 1'b0;
      seen_cause_q <= mchw_pkg::CAUSE_NONE;
    end else begin
      pending_q <= pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
      if (out_xfer && fault_o && !seen_fault_q) begin
        seen_fault_q <= 1'b1;
        seen_cause_q <= fault_cause_o;
      end
    end
  end

  `MCHW_ASSERT_IMPL(a_no_spurious_result, out_xfer, pending_q != 2'd0)
  `MCHW_ASSERT_IMPL(a_fault_sticky, out_xfer && seen_fault_q,
                    fault_o && (fault_cause_o == seen_cause_q))
  `MCHW_ASSERT_IMPL(a_refresh_clean, out_valid_o && refresh_o,
                    !fault_o && (fault_cause_o == mchw_pkg::CAUSE_NONE))
  `MCHW_ASSERT_IMPL(a_fault_has_cause, out_valid_o && fault_o,
                    (fault_cause_o == mchw_pkg::CAUSE_ZERO_PERIOD) ||
                    (fault_cause_o == mchw_pkg::CAUSE_MISSED))

endmodule

bind multi_client_heartbeat_watchdog mchw_checker u_mchw_checker (.*);

`default_nettype wire
